@@ design/assert_macros.svh @@
// Assertion helpers for the design files; only the rational arithmetic unit includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  // Result range limit: numbers are checked against WIDTH bits.
  localparam int WIDTH = 32;

  localparam int NUM_W  = 32;
  localparam int DEN_W  = 31;
  localparam int MAG_W  = 64;
  localparam int PROD_W = 65;

  // Operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (WIDTH - 1);

endpackage

@@ design/rau_if.sv @@
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] left_num;
  logic [30:0]        left_den;
  logic signed [31:0] right_num;
  logic [30:0]        right_den;

  modport source (output valid, req_type, left_num, left_den, right_num, right_den,
                  input ready);
  modport sink (input valid, req_type, left_num, left_den, right_num, right_den,
                output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               is_less;
  logic [1:0]         status;

  modport source (output valid, res_num, res_den, is_less, status, input ready);
  modport sink (input valid, res_num, res_den, is_less, status, output ready);
endinterface

@@ design/rau_mul.sv @@
// ----------------------------------------------------------------------------
// rau_mul
// Bit-serial signed multiplier, 32 x 32 bits, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rau_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [31:0]           x,
  input  logic signed [31:0]           y,
  output logic                         done,
  output logic signed [rau_pkg::PROD_W-1:0] prod
);
  import rau_pkg::*;

  logic [31:0] mcand_r, mcand_nxt;
  logic [31:0] mplr_r, mplr_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic        neg_r, neg_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sum;
  logic [PROD_W-1:0] mag;

  // Operand load on start, then shift-add steps on the magnitudes
  always_comb begin
    sum       = {1'b0, hi_r} + {1'b0, (mplr_r[0] ? mcand_r : 32'd0)};
    mcand_nxt = mcand_r;
    mplr_nxt  = mplr_r;
    hi_nxt    = hi_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      mcand_nxt = x[31] ? 32'(-x) : 32'(x);
      mplr_nxt  = y[31] ? 32'(-y) : 32'(y);
      hi_nxt    = '0;
      neg_nxt   = x[31] ^ y[31];
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      hi_nxt   = sum[32:1];
      mplr_nxt = {sum[0], mplr_r[31:1]};
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    mplr_r  <= mplr_nxt;
    hi_r    <= hi_nxt;
    neg_r   <= neg_nxt;
  end

  // Apply sign to the finished magnitude
  assign mag  = {1'b0, hi_r, mplr_r};
  assign prod = neg_r ? -$signed(mag) : $signed(mag);
  assign done = done_r;

endmodule

@@ design/rau_div.sv @@
// ----------------------------------------------------------------------------
// rau_div
// Restoring divider, 64-bit unsigned, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rau_pkg::MAG_W-1:0]   dividend,
  input  logic [rau_pkg::MAG_W-1:0]   divisor,
  output logic                        done,
  output logic [rau_pkg::MAG_W-1:0]   quotient
);
  import rau_pkg::*;

  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] quo_r, quo_nxt;
  logic [MAG_W-1:0] dvs_r, dvs_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MAG_W:0]   trial;
  logic             ge;

  // One trial subtract per cycle
  always_comb begin
    trial    = {rem_r, quo_r[MAG_W-1]};
    ge       = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? MAG_W'(trial - {1'b0, dvs_r}) : trial[MAG_W-1:0];
      quo_nxt = {quo_r[MAG_W-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ design/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: takes one request word at a time and returns one
// result word. Add, subtract, multiply and divide take three bit-serial products
// (start, 32 shift-add steps, done), a binary gcd loop of one shift or subtract
// per cycle on the 64-bit magnitudes (its length data dependent), and two serial
// divisions by the gcd. A zero result skips the gcd and the divisions. Compare
// takes two products; error and unknown opcodes skip the products and go straight
// to the output hand-over. The next request is taken once the previous result is
// placed in the output register.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply, divide and compare of signed fractions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arithmetic_unit (
  input logic      clk,
  input logic      rst_n,
  rau_in_if.sink   in_s,
  rau_out_if.source out_s
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_MUL3  = 4'd3;
  localparam logic [3:0] S_COMB  = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_DIV1  = 4'd6;
  localparam logic [3:0] S_DIV2  = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [2:0]  op_r, op_nxt;
  logic signed [31:0] ln_r, ln_nxt, rn_r, rn_nxt;
  logic [30:0] ld_r, ld_nxt, rd_r, rd_nxt;
  logic signed [PROD_W-1:0] p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [MAG_W-1:0] mn_r, mn_nxt, md_r, md_nxt, u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [5:0]  k_r, k_nxt;
  logic        neg_r, neg_nxt;
  logic signed [31:0] fnum_r, fnum_nxt;
  logic [30:0] fden_r, fden_nxt;
  logic        fless_r, fless_nxt;
  logic [1:0]  fst_r, fst_nxt;
  logic        ov_r, ov_nxt;
  logic signed [31:0] onum_r, onum_nxt;
  logic [30:0] oden_r, oden_nxt;
  logic        oless_r, oless_nxt;
  logic [1:0]  ost_r, ost_nxt;

  logic        in_acc;
  logic        mul_start, mul_done, div_start, div_done;
  logic signed [31:0] mul_x, mul_y;
  logic signed [PROD_W-1:0] mul_p;
  logic [MAG_W-1:0] div_a, div_q;
  logic signed [PROD_W-1:0] num_s, diff_s;
  logic        ovf;

  assign in_acc    = in_s.valid && in_s.ready;
  assign in_s.ready = (state_r == S_IDLE);
  assign mul_start = go_r && (state_r == S_MUL1 || state_r == S_MUL2 || state_r == S_MUL3);
  assign div_start = go_r && (state_r == S_DIV1 || state_r == S_DIV2);
  assign div_a     = (state_r == S_DIV1) ? mn_r : md_r;

  // Product operand selection: c=left_num, d=left_den, a=right_num, b=right_den
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      S_MUL1: begin
        if (op_r == OP_MUL) begin
          mul_x = rn_r;
          mul_y = ln_r;
        end else begin
          mul_x = ln_r;
          mul_y = $signed({1'b0, rd_r});
        end
      end
      S_MUL2: begin
        if (op_r == OP_ADD || op_r == OP_SUB || op_r == OP_CMP) begin
          mul_x = rn_r;
          mul_y = $signed({1'b0, ld_r});
        end
      end
      S_MUL3: begin
        mul_x = (op_r == OP_DIV) ? rn_r : $signed({1'b0, rd_r});
        mul_y = $signed({1'b0, ld_r});
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  rau_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_p)
  );

  rau_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (g_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign num_s  = (op_r == OP_SUB) ? p1_r - p2_r : p1_r + p2_r;
  assign diff_s = p1_r - mul_p;
  assign ovf    = (md_r > LIM - MAG_W'(1)) ||
                  (neg_r ? (mn_r > LIM) : (mn_r > LIM - MAG_W'(1)));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    op_nxt = op_r; ln_nxt = ln_r; ld_nxt = ld_r; rn_nxt = rn_r; rd_nxt = rd_r;
    p1_nxt = p1_r; p2_nxt = p2_r; p3_nxt = p3_r;
    mn_nxt = mn_r; md_nxt = md_r; u_nxt = u_r; v_nxt = v_r; g_nxt = g_r;
    k_nxt = k_r; neg_nxt = neg_r;
    fnum_nxt = fnum_r; fden_nxt = fden_r; fless_nxt = fless_r; fst_nxt = fst_r;
    ov_nxt = ov_r;
    onum_nxt = onum_r; oden_nxt = oden_r; oless_nxt = oless_r; ost_nxt = ost_r;

    if (out_s.valid && out_s.ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_s.req_type;
          ln_nxt = in_s.left_num;
          ld_nxt = in_s.left_den;
          rn_nxt = in_s.right_num;
          rd_nxt = in_s.right_den;
          fnum_nxt  = '0;
          fden_nxt  = 31'd1;
          fless_nxt = 1'b0;
          fst_nxt   = ST_OK;
          if (in_s.req_type > OP_CMP) begin
            state_nxt = S_DONE;
          end else if (in_s.req_type != OP_CMP &&
                       (in_s.left_den == '0 || in_s.right_den == '0 ||
                        (in_s.req_type == OP_DIV && in_s.right_num == '0))) begin
            fst_nxt   = ST_DIVZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL1;
            go_nxt    = 1'b1;
          end
        end
      end
      S_MUL1: begin
        if (mul_done) begin
          p1_nxt    = mul_p;
          state_nxt = S_MUL2;
          go_nxt    = 1'b1;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          p2_nxt = mul_p;
          if (op_r == OP_CMP) begin
            fless_nxt = diff_s[PROD_W-1];
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MUL3;
            go_nxt    = 1'b1;
          end
        end
      end
      S_MUL3: begin
        if (mul_done) begin
          p3_nxt    = mul_p;
          state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        neg_nxt = num_s[PROD_W-1] ^ p3_r[PROD_W-1];
        mn_nxt  = num_s[PROD_W-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
        md_nxt  = p3_r[PROD_W-1] ? MAG_W'(-p3_r) : MAG_W'(p3_r);
        u_nxt   = mn_nxt;
        v_nxt   = md_nxt;
        k_nxt   = '0;
        // zero result reduces to 0/1
        state_nxt = (mn_nxt == '0) ? S_DONE : S_GCD;
      end
      S_GCD: begin
        // binary gcd: one shift or subtract per cycle
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 6'd1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r == v_r) begin
          g_nxt     = u_r << k_r;
          state_nxt = S_DIV1;
          go_nxt    = 1'b1;
        end else if (u_r > v_r) begin
          u_nxt = (u_r - v_r) >> 1;
        end else begin
          v_nxt = (v_r - u_r) >> 1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          mn_nxt    = div_q;
          state_nxt = S_DIV2;
          go_nxt    = 1'b1;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          md_nxt    = div_q;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (ovf) begin
          fst_nxt = ST_OVERFLOW;
        end else begin
          fnum_nxt = neg_r ? 32'(-mn_r) : 32'(mn_r);
          fden_nxt = md_r[30:0];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_s.valid || out_s.ready) begin
          onum_nxt  = fnum_r;
          oden_nxt  = fden_r;
          oless_nxt = fless_r;
          ost_nxt   = fst_r;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
    end
    op_r <= op_nxt; ln_r <= ln_nxt; ld_r <= ld_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    p1_r <= p1_nxt; p2_r <= p2_nxt; p3_r <= p3_nxt;
    mn_r <= mn_nxt; md_r <= md_nxt; u_r <= u_nxt; v_r <= v_nxt; g_r <= g_nxt;
    k_r <= k_nxt; neg_r <= neg_nxt;
    fnum_r <= fnum_nxt; fden_r <= fden_nxt; fless_r <= fless_nxt; fst_r <= fst_nxt;
    onum_r <= onum_nxt; oden_r <= oden_nxt; oless_r <= oless_nxt; ost_r <= ost_nxt;
  end

  assign out_s.valid   = ov_r;
  assign out_s.res_num = onum_r;
  assign out_s.res_den = oden_r;
  assign out_s.is_less = oless_r;
  assign out_s.status  = ost_r;

  // Checks
  `ASSERT_IMP(a_err_zero, out_s.valid && out_s.status != ST_OK, out_s.res_num == '0 && out_s.res_den == 31'd1)
  `ASSERT_IMP(a_den_nz, out_s.valid, out_s.res_den != '0)
  `ASSERT_NEXT(a_acc_busy, in_acc, state_r != S_IDLE)
  `ASSERT_IMP(a_less_ok, out_s.valid && out_s.is_less, out_s.status == ST_OK && out_s.res_num == '0)

endmodule

@@ tb/sv/rau_tb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_tb_checker
// Watches the request and result channels of the rational arithmetic unit,
// predicts each result word from the accepted request and compares fields.
// ----------------------------------------------------------------------------
module rau_tb_checker (
  input  logic   clk,
  input  logic   rst_n,
  rau_in_if      in_w,
  rau_out_if     out_w,
  output int     fail_count,
  output int     pending_count,
  output int     result_count
);
  import rau_pkg::*;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               less;
    logic [1:0]         st;
  } frac_result_t;

  frac_result_t expected_results[$];

  // Euclid on magnitudes
  function automatic logic [63:0] gcd_u64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_result_t predict_fraction(
      input logic [2:0] op, input logic signed [31:0] ln, input logic [30:0] ld,
      input logic signed [31:0] rn, input logic [30:0] rd);
    frac_result_t r;
    logic signed [63:0] c, d, a, b, num, den, diff;
    logic [63:0] mn, md, g, lim;
    logic neg;
    r = '{num: '0, den: 31'd1, less: 1'b0, st: ST_OK};
    c = 64'(ln);
    d = {33'd0, ld};
    a = 64'(rn);
    b = {33'd0, rd};
    if (op == OP_CMP) begin
      diff = c * b - a * d;
      r.less = diff < 0;
      return r;
    end
    if (op > OP_CMP) return r;
    if (b == 0 || d == 0 || (op == OP_DIV && a == 0)) begin
      r.st = ST_DIVZERO;
      return r;
    end
    case (op)
      OP_ADD:  begin num = a * d + b * c; den = b * d; end
      OP_SUB:  begin num = c * b - a * d; den = b * d; end
      OP_MUL:  begin num = a * c; den = b * d; end
      default: begin num = b * c; den = a * d; end
    endcase
    neg = (num < 0) != (den < 0);
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    if (mn == 0) return r;
    g = gcd_u64(mn, md);
    mn = mn / g;
    md = md / g;
    lim = 64'd1 << (WIDTH - 1);
    if (md > lim - 1 || (neg ? mn > lim : mn > lim - 1)) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = neg ? -mn[31:0] : mn[31:0];
    r.den = md[30:0];
    return r;
  endfunction

  assign pending_count = expected_results.size();

  // Predict on request accept, compare on result accept
  always @(posedge clk) begin
    frac_result_t want, got;
    if (!rst_n) begin
      fail_count   <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      if (in_w.valid && in_w.ready)
        expected_results.push_back(predict_fraction(in_w.req_type, in_w.left_num,
            in_w.left_den, in_w.right_num, in_w.right_den));
      if (out_w.valid && out_w.ready) begin
        got = '{num: out_w.res_num, den: out_w.res_den, less: out_w.is_less,
                st: out_w.status};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word num=%0d den=%0d less=%0b status=%0d",
                   $time, got.num, got.den, got.less, got.st);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected num=%0d den=%0d less=%0b status=%0d",
                     $time, want.num, want.den, want.less, want.st);
            $display("%0t:          actual   num=%0d den=%0d less=%0b status=%0d",
                     $time, got.num, got.den, got.less, got.st);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_rational_arithmetic_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random fraction requests with random gaps and result
// stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int  N_RANDOM   = 430;
  localparam int  DRAIN_WAIT = 600;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, result_count;
  int   n_words = 0;
  longint cycle_count = 0;

  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit DUT (.clk(clk), .rst_n(rst_n), .in_s(in_ch.sink),
                                .out_s(out_ch.source));

  rau_tb_checker checker_i (.clk(clk), .rst_n(rst_n), .in_w(in_ch), .out_w(out_ch),
                            .fail_count(fail_count), .pending_count(pending_count),
                            .result_count(result_count));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rational_arithmetic_unit test failed");
      $finish;
    end
  end

  // Result-side stalls: a random wait before each word, a phase with none
  logic stall_free = 1'b0;
  initial begin
    int w;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      w = stall_free ? 0 : $urandom_range(0, 6);
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Valid stays high into a zero gap; the caller drops it before a drain
  task automatic send_word(input logic [2:0] op, input logic signed [31:0] ln,
                           input logic [30:0] ld, input logic signed [31:0] rn,
                           input logic [30:0] rd, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= op;
    in_ch.left_num  <= ln;
    in_ch.left_den  <= ld;
    in_ch.right_num <= rn;
    in_ch.right_den <= rd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_words++;
  endtask

  // Mostly small values, sometimes full range or edge values
  function automatic logic [31:0] pick_num();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 40)) - 20);
      4, 5:       return 32'($signed($urandom_range(0, 4000)) - 2000);
      6:          return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 31'($urandom_range(1, 30));
      4, 5:       return 31'($urandom_range(1, 5000));
      6:          return 31'h7fffffff;
      7:          return 31'd0;
      default:    return 31'($urandom);
    endcase
  endfunction

  initial begin
    int gap;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = OP_ADD;
    in_ch.left_num  = '0;
    in_ch.left_den  = 31'd1;
    in_ch.right_num = '0;
    in_ch.right_den = 31'd1;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: each operation, extremes, zero results, errors, unknown codes
    send_word(OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3, 0);
    send_word(OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2, 0);
    send_word(OP_MUL, -32'sd3, 31'd4, 32'sd8, 31'd9, 1);
    send_word(OP_DIV, 32'sd3, 31'd4, -32'sd3, 31'd8, 0);
    send_word(OP_DIV, 32'sd5, 31'd7, 32'sd0, 31'd1, 2);
    send_word(OP_CMP, 32'sd1, 31'd3, 32'sd1, 31'd2, 0);
    send_word(OP_CMP, 32'sd1, 31'd2, 32'sd1, 31'd3, 0);
    send_word(OP_CMP, 32'sd2, 31'd0, 32'sd1, 31'd0, 0);
    send_word(OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1, 0);
    send_word(OP_MUL, 32'sd1, 31'd1, 32'sd1, 31'd0, 0);
    send_word(3'd5, 32'sd1, 31'd1, 32'sd1, 31'd1, 0);
    send_word(3'd6, -32'sd1, 31'h7fffffff, 32'sd1, 31'd1, 0);
    send_word(3'd7, 32'h7fffffff, 31'h7fffffff, 32'h80000000, 31'h7fffffff, 0);
    send_word(OP_MUL, 32'h80000000, 31'd1, 32'sd1, 31'd1, 0);
    send_word(OP_MUL, 32'h80000000, 31'd1, -32'sd1, 31'd1, 0);
    send_word(OP_ADD, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1, 0);
    send_word(OP_SUB, 32'h80000000, 31'h7fffffff, 32'h7fffffff, 31'h7fffffff, 0);
    send_word(OP_DIV, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7fffffff, 0);
    send_word(OP_MUL, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7fffffff, 0);
    send_word(OP_CMP, 32'h80000000, 31'd1, 32'h7fffffff, 31'h7fffffff, 0);
    send_word(OP_DIV, 32'sd1, 31'h7fffffff, 32'sd2, 31'd1, 0);
    send_word(OP_ADD, 32'sd0, 31'd5, 32'sd0, 31'd9, 0);
    in_ch.valid <= 1'b0;

    // Hold off until every expected word has returned
    while (pending_count != 0) @(negedge clk);

    // Random phase; a stretch in the middle runs with no gaps or stalls
    for (int i = 0; i < N_RANDOM; i++) begin
      stall_free = (i >= 200 && i < 240);
      gap = stall_free ? 0 : $urandom_range(0, 6);
      send_word(3'($urandom_range(0, 7) < 7 ? $urandom_range(0, 4) : $urandom_range(5, 7)),
                pick_num(), pick_den(), pick_num(), pick_den(), gap);
    end
    in_ch.valid <= 1'b0;
    stall_free = 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d request words (all opcodes, edge values, zero denominators),", n_words);
    $display("checked %0d result words under random gaps and output stalls.", result_count);
    if (fail_count == 0 && pending_count == 0)
      $display("rational_arithmetic_unit test passed");
    else
      $display("rational_arithmetic_unit test failed");
    $finish;
  end

endmodule

@@ rational_arithmetic_unit.f @@
+incdir+design
design/rau_pkg.sv
design/rau_if.sv
design/rau_mul.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
tb/sv/rau_tb_checker.sv
tb/sv/tb_rational_arithmetic_unit.sv
